@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the A5/1 keystream RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define A51_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define A51_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/a51_pkg.sv @@
// Shared constants, types and sequencer states for the A5/1 keystream generator.
// No dependencies.
`default_nettype none

package a51_pkg;

    localparam int KEY_BITS       = 64;
    localparam int FRAME_BITS     = 22;
    localparam int MIX_CLOCKS     = 100;
    localparam int BITS_PER_BURST = 114;

    localparam int ONE_W   = 19;
    localparam int TWO_W   = 22;
    localparam int THREE_W = 23;

    localparam logic [ONE_W-1:0]   ONE_TAPS   = 19'h72000;
    localparam logic [TWO_W-1:0]   TWO_TAPS   = 22'h300000;
    localparam logic [THREE_W-1:0] THREE_TAPS = 23'h700080;

    localparam int ONE_CLK   = 8;
    localparam int TWO_CLK   = 10;
    localparam int THREE_CLK = 10;

    // Longest phase sets the counter width.
    localparam int MAX_A     = (KEY_BITS > MIX_CLOCKS) ? KEY_BITS : MIX_CLOCKS;
    localparam int MAX_PHASE = (MAX_A > BITS_PER_BURST) ? MAX_A : BITS_PER_BURST;
    localparam int CNT_W     = (MAX_PHASE > 1) ? $clog2(MAX_PHASE) : 1;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_KEY   = 5'b00010,
        S_FRAME = 5'b00100,
        S_MIX   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic clear;
        logic clock_all;
        logic clock_maj;
        logic in_bit;
    } t_lfsr_ctrl;

endpackage

`default_nettype wire

@@ hw/rtl/a51_lfsr_unit.sv @@
// Shared stepping unit: the three A5/1 shift registers with clear, load and majority clocking.
// Depends on a51_pkg.
`default_nettype none

module a51_lfsr_unit
    import a51_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_lfsr_ctrl i_ctrl,
    output logic            o_bit
);

    logic [ONE_W-1:0]   r_one,   n_one,   sh_one;
    logic [TWO_W-1:0]   r_two,   n_two,   sh_two;
    logic [THREE_W-1:0] r_three, n_three, sh_three;
    logic a, b, c, maj;
    logic step_one, step_two, step_three;

    always_comb begin
        sh_one   = {r_one[ONE_W-2:0],     ^(r_one & ONE_TAPS)};
        sh_two   = {r_two[TWO_W-2:0],     ^(r_two & TWO_TAPS)};
        sh_three = {r_three[THREE_W-2:0], ^(r_three & THREE_TAPS)};

        a   = r_one[ONE_CLK];
        b   = r_two[TWO_CLK];
        c   = r_three[THREE_CLK];
        maj = (a & b) | (a & c) | (b & c);

        step_one   = i_ctrl.clock_all | (i_ctrl.clock_maj & (a == maj));
        step_two   = i_ctrl.clock_all | (i_ctrl.clock_maj & (b == maj));
        step_three = i_ctrl.clock_all | (i_ctrl.clock_maj & (c == maj));

        n_one   = step_one   ? sh_one   : r_one;
        n_two   = step_two   ? sh_two   : r_two;
        n_three = step_three ? sh_three : r_three;

        // fold the loaded bit into bit 0 after the shift
        n_one[0]   = n_one[0]   ^ i_ctrl.in_bit;
        n_two[0]   = n_two[0]   ^ i_ctrl.in_bit;
        n_three[0] = n_three[0] ^ i_ctrl.in_bit;

        if (i_ctrl.clear) begin
            n_one   = '0;
            n_two   = '0;
            n_three = '0;
        end

        // keystream bit is taken after the clock
        o_bit = n_one[ONE_W-1] ^ n_two[TWO_W-1] ^ n_three[THREE_W-1];
    end

    always_ff @(posedge i_clk) begin
        r_one   <= n_one;
        r_two   <= n_two;
        r_three <= n_three;
    end

endmodule

`default_nettype wire

@@ hw/rtl/a51_sequencer.sv @@
// Phase sequencer: key and frame loading, mixing, keystream byte packing and result strobes.
// Depends on a51_pkg and assert_macros.svh; drives a51_lfsr_unit.
`default_nettype none
`include "assert_macros.svh"

module a51_sequencer
    import a51_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [FRAME_BITS-1:0] i_frame_number,
    input  wire logic                  i_bit,
    output t_lfsr_ctrl                 o_ctrl,
    output logic                       o_busy,
    output logic                       o_strobe,
    output logic [7:0]                 o_keystream_byte,
    output logic                       o_direction,
    output logic                       o_last_byte
);

    t_state                r_state, n_state;
    t_cnt                  r_cnt,   n_cnt;
    logic                  r_dir,   n_dir;
    logic [KEY_BITS-1:0]   r_key,   n_key;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [7:0]            r_gather, n_gather;
    logic                  r_valid, n_valid;
    logic [7:0]            r_obyte, n_obyte;
    logic                  r_odir,  n_odir;
    logic                  r_olast, n_olast;

    logic [2:0] pos;
    logic [7:0] cur_byte;
    logic       burst_end;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_dir    = r_dir;
        n_key    = r_key;
        n_frame  = r_frame;
        n_gather = r_gather;
        n_valid  = 1'b0;
        n_obyte  = r_obyte;
        n_odir   = r_odir;
        n_olast  = r_olast;
        o_ctrl   = '0;

        pos       = r_cnt[2:0];
        cur_byte  = r_gather | ({7'b0, i_bit} << (3'd7 - pos));
        burst_end = (r_cnt == t_cnt'(BITS_PER_BURST - 1));

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.clear = 1'b1;
                    n_state      = S_KEY;
                    n_cnt        = '0;
                    n_key        = i_key;
                    n_frame      = i_frame_number;
                end
            end
            S_KEY: begin
                o_ctrl.clock_all = 1'b1;
                o_ctrl.in_bit    = r_key[0];
                n_key            = r_key >> 1;
                if (r_cnt == t_cnt'(KEY_BITS - 1)) begin
                    n_state = S_FRAME;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FRAME: begin
                o_ctrl.clock_all = 1'b1;
                o_ctrl.in_bit    = r_frame[0];
                n_frame          = r_frame >> 1;
                if (r_cnt == t_cnt'(FRAME_BITS - 1)) begin
                    n_state = S_MIX;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MIX: begin
                o_ctrl.clock_maj = 1'b1;
                if (r_cnt == t_cnt'(MIX_CLOCKS - 1)) begin
                    n_state  = S_OUT;
                    n_cnt    = '0;
                    n_dir    = 1'b0;
                    n_gather = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                o_ctrl.clock_maj = 1'b1;
                // emit on a full byte or on the short tail of the burst
                if (pos == 3'd7 || burst_end) begin
                    n_valid  = 1'b1;
                    n_obyte  = cur_byte;
                    n_odir   = r_dir;
                    n_olast  = r_dir & burst_end;
                    n_gather = '0;
                end else begin
                    n_gather = cur_byte;
                end
                if (burst_end) begin
                    n_cnt = '0;
                    if (r_dir) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dir = 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dir   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dir   <= n_dir;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_frame  <= n_frame;
        r_gather <= n_gather;
        r_obyte  <= n_obyte;
        r_odir   <= n_odir;
        r_olast  <= n_olast;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_strobe         = r_valid;
    assign o_keystream_byte = r_obyte;
    assign o_direction      = r_odir;
    assign o_last_byte      = r_valid & r_olast;

    `A51_ASSERT(a_state_onehot, $onehot(r_state), "sequencer state not one-hot")
    `A51_ASSERT(a_strobe_from_out, o_strobe |-> $past(r_state == S_OUT), "strobe outside output phase")
    `A51_ASSERT(a_last_is_uplink, o_last_byte |-> (o_strobe && o_direction), "last byte not uplink")
    `A51_ASSERT(a_start_enters_key, (i_start && !o_busy) |=> (r_state == S_KEY), "start not taken")
    `A51_ASSERT(a_one_clock_mode, !(o_ctrl.clock_all && o_ctrl.clock_maj), "two clock modes at once")
    `A51_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !o_strobe), "reset not idle")

endmodule

`default_nettype wire

@@ hw/rtl/a51_keystream_generator_core.sv @@
// A5/1 keystream generator, top level: start/busy frame channel, strobed byte results,
// session key register. Depends on a51_pkg, a51_sequencer and a51_lfsr_unit.
//
// Usage:
//   Write the 64-bit session key with i_cfg_we / i_cfg_wdata while busy is low.
//   Pulse start with i_frame_number while busy is low; the frame is taken on
//   that edge and busy rises on the next cycle.
//   The shift registers are cleared, then clocked once per cycle: 64 key clocks,
//   22 frame clocks, 100 majority mixing clocks, then 114 downlink and 114
//   uplink keystream clocks, one bit each. Busy stays high from the first key
//   clock to the last uplink clock, one clock of the shared shift-register unit
//   per cycle; the next frame may start on the cycle busy falls.
//   Results: 15 downlink then 15 uplink bytes, each on the output ports for one
//   cycle with o_strobe high, first keystream bit in bit 7; the last byte of a
//   direction carries 2 bits and is zero-padded. o_last_byte marks the final
//   uplink byte. Each byte, the last one included, is strobed in the cycle after
//   its final keystream clock.
//   The receiver cannot stall: every strobed byte must be taken.
//   Reset (synchronous, active low) returns to idle, drops any frame in
//   progress and clears the key to zero.
`default_nettype none

module a51_keystream_generator_core
    import a51_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [FRAME_BITS-1:0] i_frame_number,
    input  wire logic                  i_cfg_we,
    input  wire logic [KEY_BITS-1:0]   i_cfg_wdata,
    output logic                       o_strobe,
    output logic [7:0]                 o_keystream_byte,
    output logic                       o_direction,
    output logic                       o_last_byte
);

    logic [KEY_BITS-1:0] r_session_key;
    t_lfsr_ctrl          ctrl;
    logic                ks_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_key <= '0;
        end else if (i_cfg_we) begin
            r_session_key <= i_cfg_wdata;
        end
    end

    a51_sequencer u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_key            (r_session_key),
        .i_frame_number   (i_frame_number),
        .i_bit            (ks_bit),
        .o_ctrl           (ctrl),
        .o_busy           (busy),
        .o_strobe         (o_strobe),
        .o_keystream_byte (o_keystream_byte),
        .o_direction      (o_direction),
        .o_last_byte      (o_last_byte)
    );

    a51_lfsr_unit u_lfsr (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .o_bit  (ks_bit)
    );

endmodule

`default_nettype wire

@@ bench/a51_keystream_checker.sv @@
// Keystream checker: models the A5/1 generator, queues the bytes each frame must give
// and compares the strobed bytes. Depends on a51_pkg; instantiated by tb.
module a51_keystream_checker
    import a51_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [FRAME_BITS-1:0] i_frame_number,
    input  wire logic                  i_cfg_we,
    input  wire logic [KEY_BITS-1:0]   i_cfg_wdata,
    input  wire logic                  i_strobe,
    input  wire logic [7:0]            i_keystream_byte,
    input  wire logic                  i_direction,
    input  wire logic                  i_last_byte,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic DIR_DOWNLINK = 1'b0;
    localparam logic DIR_UPLINK   = 1'b1;
    localparam int   REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] kbyte;
        logic       dir;
        logic       last;
    } t_keystream_rec;

    t_keystream_rec      expected_bytes[$];
    logic [KEY_BITS-1:0] model_key;
    int                  fails;
    int                  checked;

    function automatic logic [ONE_W-1:0] step_one(input logic [ONE_W-1:0] r);
        return {r[ONE_W-2:0], ^(r & ONE_TAPS)};
    endfunction

    function automatic logic [TWO_W-1:0] step_two(input logic [TWO_W-1:0] r);
        return {r[TWO_W-2:0], ^(r & TWO_TAPS)};
    endfunction

    function automatic logic [THREE_W-1:0] step_three(input logic [THREE_W-1:0] r);
        return {r[THREE_W-2:0], ^(r & THREE_TAPS)};
    endfunction

    // Work out all keystream bytes of one frame and append them to the queue.
    function automatic void queue_frame_keystream(input logic [KEY_BITS-1:0] key,
                                                  input logic [FRAME_BITS-1:0] fn);
        logic [ONE_W-1:0]   r1;
        logic [TWO_W-1:0]   r2;
        logic [THREE_W-1:0] r3;
        logic               a, b, c, maj, bit_in;
        logic [7:0]         acc;
        t_keystream_rec     rec;
        int                 nbytes, cnt;
        r1 = '0;
        r2 = '0;
        r3 = '0;
        cnt = 0;
        nbytes = (BITS_PER_BURST + 7) / 8;
        for (int k = 0; k < KEY_BITS + FRAME_BITS; k++) begin
            bit_in = (k < KEY_BITS) ? key[k] : fn[k - KEY_BITS];
            r1 = step_one(r1);
            r2 = step_two(r2);
            r3 = step_three(r3);
            r1[0] = r1[0] ^ bit_in;
            r2[0] = r2[0] ^ bit_in;
            r3[0] = r3[0] ^ bit_in;
        end
        // Mixing clocks, then one majority clock per keystream bit.
        for (int k = 0; k < MIX_CLOCKS + 2 * BITS_PER_BURST; k++) begin
            a = r1[ONE_CLK];
            b = r2[TWO_CLK];
            c = r3[THREE_CLK];
            maj = (a & b) | (a & c) | (b & c);
            if (a == maj) r1 = step_one(r1);
            if (b == maj) r2 = step_two(r2);
            if (c == maj) r3 = step_three(r3);
            if (k >= MIX_CLOCKS) begin
                int p;
                p = (k - MIX_CLOCKS) % BITS_PER_BURST;
                if (p == 0) acc = '0;
                acc[7 - (p % 8)] = r1[ONE_W-1] ^ r2[TWO_W-1] ^ r3[THREE_W-1];
                if ((p % 8) == 7 || p + 1 == BITS_PER_BURST) begin
                    rec.kbyte = acc;
                    rec.dir   = (k - MIX_CLOCKS < BITS_PER_BURST) ? DIR_DOWNLINK : DIR_UPLINK;
                    rec.last  = (rec.dir == DIR_UPLINK) && (cnt + 1 == 2 * nbytes);
                    expected_bytes.push_back(rec);
                    cnt++;
                    acc = '0;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_keystream_rec want;
        if (!i_rst_n) begin
            model_key = '0;
            expected_bytes.delete();
            fails = 0;
            checked = 0;
        end else begin
            if (i_cfg_we) model_key = i_cfg_wdata;
            if (i_start && !i_busy) queue_frame_keystream(model_key, i_frame_number);
            if (i_strobe) begin
                if (expected_bytes.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: unexpected keystream byte %02h dir %0b last %0b",
                                 $realtime, i_keystream_byte, i_direction, i_last_byte);
                end else begin
                    want = expected_bytes.pop_front();
                    checked++;
                    if (want.kbyte !== i_keystream_byte || want.dir !== i_direction ||
                        want.last !== i_last_byte) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("%0t: byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                                     $realtime, want.kbyte, want.dir, want.last,
                                     i_keystream_byte, i_direction, i_last_byte);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_bytes.size();
        o_checked    <= checked;
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for the A5/1 keystream generator: clock, reset, frame and key stimulus,
// watchdog and verdict. Depends on a51_pkg, a51_keystream_checker and the RTL top.
module tb;
    import a51_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 430;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [FRAME_BITS-1:0] i_frame_number;
    logic                  i_cfg_we;
    logic [KEY_BITS-1:0]   i_cfg_wdata;
    logic                  o_strobe;
    logic [7:0]            o_keystream_byte;
    logic                  o_direction;
    logic                  o_last_byte;

    int fail_count, pending, checked;
    int frames_sent, keys_written, idle_cycles;

    a51_keystream_generator_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_frame_number   (i_frame_number),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_strobe         (o_strobe),
        .o_keystream_byte (o_keystream_byte),
        .o_direction      (o_direction),
        .o_last_byte      (o_last_byte)
    );

    a51_keystream_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_frame_number   (i_frame_number),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_strobe         (o_strobe),
        .i_keystream_byte (o_keystream_byte),
        .i_direction      (o_direction),
        .i_last_byte      (o_last_byte),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hold start high until the frame is taken; start stays high on return.
    task automatic send_frame(input logic [FRAME_BITS-1:0] fn);
        start <= 1'b1;
        i_frame_number <= fn;
        do @(posedge i_clk); while (busy);
        frames_sent++;
    endtask

    // Idle gap after a transaction: often none, mostly short, now and then long.
    task automatic frame_gap();
        int r, g;
        r = $urandom_range(0, 99);
        if (r < 30) g = 0;
        else if (r < 88) g = $urandom_range(1, 4);
        else g = $urandom_range(20, 600);
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every byte has come and the block is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key(input logic [KEY_BITS-1:0] k);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        keys_written++;
    endtask

    function automatic logic [FRAME_BITS-1:0] pick_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        if (r < 15) return FRAME_BITS'(1) << $urandom_range(0, FRAME_BITS - 1);
        return FRAME_BITS'($urandom);
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key(input int phase);
        case (phase % 6)
            0: return '1;
            1: return '0;
            2: return {32'hAAAAAAAA, 32'hAAAAAAAA};
            3: return KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_frame_number = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        frames_sent = 0;
        keys_written = 0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset key, then extreme and known keys with extreme, alternating and known frames.
        send_frame('0);
        send_frame('1);
        drain();
        write_key('1);
        send_frame('0);
        send_frame('1);
        frame_gap();
        send_frame(22'h155555);
        send_frame(22'h2AAAAA);
        drain();
        write_key(64'hEFCDAB8967452312);
        send_frame(22'h000134);
        send_frame(22'h000001);
        drain();
        write_key(64'h0000000000000001);
        send_frame(22'h200000);
        send_frame('0);
        drain();
        write_key(64'h8000000000000000);
        send_frame(22'h000001);
        send_frame('1);
        drain();
        write_key('0);
        send_frame(22'h200000);
        send_frame(22'h155555);
        drain();

        // Random frames in phases, a new key between phases.
        for (int phase = 0; phase < 12; phase++) begin
            write_key(pick_key(phase));
            for (int n = 0; n < 35; n++) begin
                send_frame(pick_frame());
                frame_gap();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $display("%0d expected keystream bytes never arrived", pending);
        $display("Ran %0d frames under %0d key writes, %0d keystream bytes compared.",
                 frames_sent, keys_written, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
